/* rtl/plut_pkg.sv */
// ----------------------------------------------------------------------------
// plut_pkg
// Shared types and constants of the load-use pipeline timing model.
// ----------------------------------------------------------------------------
package plut_pkg;

   // default widths of the stamp counter and the fetch order counter
   localparam int CYCLE_BITS_DEF = 32;
   localparam int SEQ_BITS_DEF   = 16;

   // number of architectural registers; higher numbers mean "no register"
   localparam int REG_COUNT = 32;

   localparam int KIND_W = 2;
   localparam int REGN_W = 6;

   // instruction kinds
   localparam logic [KIND_W-1:0] KIND_REG   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IMM   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STORE = 2'd3;

   typedef logic [31:0] stamp_type;
   typedef logic [15:0] rseq_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [REGN_W-1:0] dest;
      logic [REGN_W-1:0] src_a;
      logic [REGN_W-1:0] src_b;
   } inst_type;

   typedef struct packed {
      logic      fetch_taken;
      logic      retire_valid;
      rseq_type  retire_seq;
      stamp_type fetch_cycle;
      stamp_type decode_cycle;
      stamp_type execute_cycle;
      stamp_type memory_cycle;
      stamp_type writeback_cycle;
   } result_type;

endpackage

/* rtl/pipeline_load_use_timing_model.sv */
// ----------------------------------------------------------------------------
// pipeline_load_use_timing_model
// Cycle-stamp timing model of a five-stage in-order pipeline with forwarding.
// ----------------------------------------------------------------------------
// Usage:
//   Each req_ transfer is one modeled pipeline tick, optionally offering one
//   instruction (req_fetch_valid). Each tick yields exactly one rsp_ transfer:
//   whether the offer was fetched (re-offer it otherwise) and, when an
//   instruction left writeback, its sequence number and five stage stamps.
//   The response for a tick is registered and presented in the clock after the
//   request transfer. Throughput: one tick per clock while rsp_ready is high.
//   The response sits in an output register; a new request is taken in the
//   same clock that the held response is taken, so the model runs back to
//   back. When the receiver stalls, req_ready drops and the model state holds.
//   Reset empties all pipeline latches and clears the stamp counter and the
//   fetch order counter; no response is pending after reset.
//   Hazard: a load in execute writing a source register of the instruction in
//   decode holds decode one tick, refuses fetch and inserts a bubble.
// ----------------------------------------------------------------------------
module pipeline_load_use_timing_model #(
   parameter int CYCLE_BITS = plut_pkg::CYCLE_BITS_DEF,
   parameter int SEQ_BITS   = plut_pkg::SEQ_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_fetch_valid,
   input  logic [1:0]         req_inst_type,
   input  logic signed [5:0]  req_dest_reg,
   input  logic signed [5:0]  req_src_reg_a,
   input  logic signed [5:0]  req_src_reg_b,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_fetch_taken,
   output logic               rsp_retire_valid,
   output logic [15:0]        rsp_retire_seq,
   output logic [31:0]        rsp_fetch_cycle,
   output logic [31:0]        rsp_decode_cycle,
   output logic [31:0]        rsp_execute_cycle,
   output logic [31:0]        rsp_memory_cycle,
   output logic [31:0]        rsp_writeback_cycle
);

   logic                 rsp_valid_ff;
   plut_pkg::result_type rsp_data_ff;
   plut_pkg::result_type result;
   plut_pkg::inst_type   fetch_inst;
   logic                 advance;

   // take a tick when the output register is empty or drains this clock
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid && req_ready;

   always_comb begin
      fetch_inst.kind  = req_inst_type;
      fetch_inst.dest  = req_dest_reg;
      fetch_inst.src_a = req_src_reg_a;
      fetch_inst.src_b = req_src_reg_b;
   end

   plut_pipe #(
      .CYCLE_BITS (CYCLE_BITS),
      .SEQ_BITS   (SEQ_BITS)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .fetch_valid (req_fetch_valid),
      .fetch_inst  (fetch_inst),
      .result      (result)
   );

   // hold the response until transfer; drop valid once taken with no refill
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fetch_taken     = rsp_data_ff.fetch_taken;
   assign rsp_retire_valid    = rsp_data_ff.retire_valid;
   assign rsp_retire_seq      = rsp_data_ff.retire_seq;
   assign rsp_fetch_cycle     = rsp_data_ff.fetch_cycle;
   assign rsp_decode_cycle    = rsp_data_ff.decode_cycle;
   assign rsp_execute_cycle   = rsp_data_ff.execute_cycle;
   assign rsp_memory_cycle    = rsp_data_ff.memory_cycle;
   assign rsp_writeback_cycle = rsp_data_ff.writeback_cycle;

endmodule

/* rtl/plut_hazard.sv */
// ----------------------------------------------------------------------------
// plut_hazard
// Load-use hazard detect between the decode and execute latches.
// ----------------------------------------------------------------------------
module plut_hazard (
   input  logic              dec_valid,
   input  plut_pkg::inst_type dec_inst,
   input  logic              exe_valid,
   input  plut_pkg::inst_type exe_inst,
   output logic              stall
);

   // a register number outside 0..REG_COUNT-1 names no register
   function automatic logic reg_ok(input logic [plut_pkg::REGN_W-1:0] raw);
      return !raw[plut_pkg::REGN_W-1] &&
             ({1'b0, raw} < (plut_pkg::REGN_W+1)'(plut_pkg::REG_COUNT));
   endfunction

   logic dest_ok;
   logic hit_a;
   logic hit_b;

   always_comb begin
      dest_ok = reg_ok(exe_inst.dest);
      hit_a   = reg_ok(dec_inst.src_a) && (dec_inst.src_a == exe_inst.dest);
      hit_b   = reg_ok(dec_inst.src_b) && (dec_inst.src_b == exe_inst.dest);
      stall   = dec_valid && exe_valid && (exe_inst.kind == plut_pkg::KIND_LOAD) &&
                dest_ok && (hit_a || hit_b);
   end

endmodule

/* rtl/plut_pipe.sv */
// ----------------------------------------------------------------------------
// plut_pipe
// Pipeline latches, stage stamps and the per-tick result.
// ----------------------------------------------------------------------------
module plut_pipe #(
   parameter int CYCLE_BITS = plut_pkg::CYCLE_BITS_DEF,
   parameter int SEQ_BITS   = plut_pkg::SEQ_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 fetch_valid,
   input  plut_pkg::inst_type   fetch_inst,
   output plut_pkg::result_type result
);

   logic [CYCLE_BITS-1:0] cycle_ff;
   logic [SEQ_BITS-1:0]   fseq_ff;
   logic [3:0]            valid_ff;
   logic [3:0]            valid_in;

   plut_pkg::inst_type    dec_inst_ff;
   plut_pkg::inst_type    exe_inst_ff;
   logic [SEQ_BITS-1:0]   seq_ff [4];

   // stamps carried by each latch: fetch, decode, execute, memory
   logic [CYCLE_BITS-1:0] fd_stamp_ff;
   logic [CYCLE_BITS-1:0] de_stamp_ff [2];
   logic [CYCLE_BITS-1:0] em_stamp_ff [3];
   logic [CYCLE_BITS-1:0] mw_stamp_ff [4];

   logic stall;
   logic take;

   plut_hazard u_hazard (
      .dec_valid (valid_ff[0]),
      .dec_inst  (dec_inst_ff),
      .exe_valid (valid_ff[1]),
      .exe_inst  (exe_inst_ff),
      .stall     (stall)
   );

   always_comb begin
      take        = fetch_valid && !stall;
      valid_in[3] = valid_ff[2];
      valid_in[2] = valid_ff[1];
      valid_in[1] = valid_ff[0] && !stall;
      valid_in[0] = take || (valid_ff[0] && stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_ff <= '0;
         fseq_ff  <= '0;
         valid_ff <= '0;
      end else if (advance) begin
         cycle_ff <= cycle_ff + 1'b1;
         valid_ff <= valid_in;
         if (take) begin
            fseq_ff <= fseq_ff + 1'b1;
         end
      end
   end

   // payload: contents of an empty latch are never read
   always_ff @(posedge clock) begin
      if (advance) begin
         mw_stamp_ff[0] <= em_stamp_ff[0];
         mw_stamp_ff[1] <= em_stamp_ff[1];
         mw_stamp_ff[2] <= em_stamp_ff[2];
         mw_stamp_ff[3] <= cycle_ff;
         seq_ff[3]      <= seq_ff[2];

         em_stamp_ff[0] <= de_stamp_ff[0];
         em_stamp_ff[1] <= de_stamp_ff[1];
         em_stamp_ff[2] <= cycle_ff;
         seq_ff[2]      <= seq_ff[1];

         if (!stall) begin
            exe_inst_ff    <= dec_inst_ff;
            de_stamp_ff[0] <= fd_stamp_ff;
            de_stamp_ff[1] <= cycle_ff;
            seq_ff[1]      <= seq_ff[0];
         end

         if (take) begin
            dec_inst_ff <= fetch_inst;
            fd_stamp_ff <= cycle_ff;
            seq_ff[0]   <= fseq_ff;
         end
      end
   end

   always_comb begin
      result              = '0;
      result.fetch_taken  = fetch_valid && !stall;
      result.retire_valid = valid_ff[3];
      if (valid_ff[3]) begin
         result.retire_seq      = plut_pkg::rseq_type'(seq_ff[3]);
         result.fetch_cycle     = plut_pkg::stamp_type'(mw_stamp_ff[0]);
         result.decode_cycle    = plut_pkg::stamp_type'(mw_stamp_ff[1]);
         result.execute_cycle   = plut_pkg::stamp_type'(mw_stamp_ff[2]);
         result.memory_cycle    = plut_pkg::stamp_type'(mw_stamp_ff[3]);
         result.writeback_cycle = plut_pkg::stamp_type'(cycle_ff);
      end
   end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the load-use pipeline timing model. A cycle-stamp
// model of the five-stage pipeline runs beside the block. Every request
// transfer advances it by one tick and queues the response it must produce.
// Directed ticks cover field extremes and load-use stalls. A long random
// stream follows, mostly well-formed instructions over a few registers, with
// random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         STALL_LIMIT  = 2000;  // cycles without any transfer
   localparam int         RANDOM_TICKS = 520;
   localparam logic [5:0] NO_REG       = 6'h3F; // -1, no register
   localparam logic [5:0] NEG_REG      = 6'h20; // -32, also no register

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic              req_fetch_valid  = 1'b0;
   logic [1:0]        req_inst_type    = plut_pkg::KIND_REG;
   logic signed [5:0] req_dest_reg     = '1;
   logic signed [5:0] req_src_reg_a    = '1;
   logic signed [5:0] req_src_reg_b    = '1;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic              rsp_fetch_taken;
   logic              rsp_retire_valid;
   logic [15:0]       rsp_retire_seq;
   logic [31:0]       rsp_fetch_cycle;
   logic [31:0]       rsp_decode_cycle;
   logic [31:0]       rsp_execute_cycle;
   logic [31:0]       rsp_memory_cycle;
   logic [31:0]       rsp_writeback_cycle;

   // idling switches for the two channels, set by the test tasks
   bit req_idle_on = 1'b0;
   bit rsp_idle_on = 1'b0;

   int ticks_sent     = 0;
   int mismatch_count = 0;
   int quiet_cycles   = 0;

   // Pipeline model state. Latch 0 is fetch-decode, 1 decode-execute,
   // 2 execute-memory, 3 memory-writeback. Stamps: latch 0 holds [0],
   // latch 1 [1..2], latch 2 [3..5], latch 3 [6..9].
   logic [31:0]         tick_count      = '0;
   plut_pkg::rseq_type  next_seq        = '0;
   logic                stage_full [4]  = '{default: 1'b0};
   plut_pkg::inst_type  stage_inst [2]  = '{default: '0};
   plut_pkg::rseq_type  stage_seq  [4]  = '{default: '0};
   plut_pkg::stamp_type stage_stamp[10] = '{default: '0};

   // responses the block owes, oldest first
   plut_pkg::result_type pending_results[$];

   pipeline_load_use_timing_model u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_fetch_valid     (req_fetch_valid),
      .req_inst_type       (req_inst_type),
      .req_dest_reg        (req_dest_reg),
      .req_src_reg_a       (req_src_reg_a),
      .req_src_reg_b       (req_src_reg_b),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_fetch_taken     (rsp_fetch_taken),
      .rsp_retire_valid    (rsp_retire_valid),
      .rsp_retire_seq      (rsp_retire_seq),
      .rsp_fetch_cycle     (rsp_fetch_cycle),
      .rsp_decode_cycle    (rsp_decode_cycle),
      .rsp_execute_cycle   (rsp_execute_cycle),
      .rsp_memory_cycle    (rsp_memory_cycle),
      .rsp_writeback_cycle (rsp_writeback_cycle)
   );

   always #4 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Map a 6-bit signed register field to its index; anything outside the
   // register file reads as -1 and never matches.
   function automatic int reg_index(logic [5:0] r);
      if ($signed(r) < 0 || $signed(r) >= plut_pkg::REG_COUNT) return -1;
      return int'($signed(r));
   endfunction

   // Advance the pipeline model by one tick and queue the response it gives.
   // Stages go back to front from the state at the start of the tick.
   task automatic advance_pipeline_model(input logic fv,
                                         input plut_pkg::inst_type offered,
                                         output logic taken);
      plut_pkg::result_type res;
      plut_pkg::stamp_type  c;
      logic                 stall;
      int                   dst;
      c     = tick_count;
      res   = '0;
      stall = 1'b0;
      // load-use: a load in execute writes a source of the one in decode
      if (stage_full[0] && stage_full[1] &&
          stage_inst[1].kind == plut_pkg::KIND_LOAD) begin
         dst   = reg_index(stage_inst[1].dest);
         stall = dst >= 0 && (reg_index(stage_inst[0].src_a) == dst ||
                              reg_index(stage_inst[0].src_b) == dst);
      end
      // writeback: report the retiring instruction
      if (stage_full[3]) begin
         res.retire_valid    = 1'b1;
         res.retire_seq      = stage_seq[3];
         res.fetch_cycle     = stage_stamp[6];
         res.decode_cycle    = stage_stamp[7];
         res.execute_cycle   = stage_stamp[8];
         res.memory_cycle    = stage_stamp[9];
         res.writeback_cycle = c;
      end
      // memory
      stage_full[3] = stage_full[2];
      if (stage_full[2]) begin
         stage_seq[3]   = stage_seq[2];
         stage_stamp[6] = stage_stamp[3];
         stage_stamp[7] = stage_stamp[4];
         stage_stamp[8] = stage_stamp[5];
         stage_stamp[9] = c;
      end
      // execute
      stage_full[2] = stage_full[1];
      if (stage_full[1]) begin
         stage_seq[2]   = stage_seq[1];
         stage_stamp[3] = stage_stamp[1];
         stage_stamp[4] = stage_stamp[2];
         stage_stamp[5] = c;
      end
      // decode: a stall holds latch 0 and leaves a bubble behind it
      if (stage_full[0] && !stall) begin
         stage_inst[1]  = stage_inst[0];
         stage_seq[1]   = stage_seq[0];
         stage_stamp[1] = stage_stamp[0];
         stage_stamp[2] = c;
         stage_full[1]  = 1'b1;
         stage_full[0]  = 1'b0;
      end else begin
         stage_full[1] = 1'b0;
      end
      // fetch
      if (!stall && fv) begin
         stage_inst[0]    = offered;
         stage_seq[0]     = next_seq;
         stage_stamp[0]   = c;
         stage_full[0]    = 1'b1;
         next_seq         = next_seq + 1'b1;
         res.fetch_taken  = 1'b1;
      end
      tick_count = tick_count + 1;
      pending_results.push_back(res);
      taken = res.fetch_taken;
   endtask

   // Send one tick. Valid stays high after the transfer; only a gap or a
   // drain lowers it.
   task automatic send_tick(input logic fv, input plut_pkg::inst_type offered,
                            output logic taken);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_fetch_valid <= fv;
      req_inst_type   <= offered.kind;
      req_dest_reg    <= offered.dest;
      req_src_reg_a   <= offered.src_a;
      req_src_reg_b   <= offered.src_b;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
      advance_pipeline_model(fv, offered, taken);
   endtask

   // Offer one instruction and re-offer it until fetch takes it.
   task automatic issue(input logic [1:0] kind, input logic [5:0] d, a, b);
      plut_pkg::inst_type inst;
      logic               taken;
      inst.kind  = kind;
      inst.dest  = d;
      inst.src_a = a;
      inst.src_b = b;
      do send_tick(1'b1, inst, taken); while (!taken);
   endtask

   // A tick with no offer; the payload is random and must be ignored.
   task automatic bubble_tick();
      logic [31:0] r;
      logic        taken;
      r = $urandom;
      send_tick(1'b0, r[19:0], taken);
   endtask

   // Drop valid and hold off until every owed response has come.
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Extremes of every field, every instruction kind, a no-offer tick.
   task automatic test_field_extremes();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      issue(plut_pkg::KIND_REG,   6'd31,  6'd0,    6'd31);
      issue(plut_pkg::KIND_IMM,   6'd0,   NO_REG,  NO_REG);
      issue(plut_pkg::KIND_STORE, NO_REG, 6'd31,   6'd0);
      issue(plut_pkg::KIND_LOAD,  6'd1,   NEG_REG, NO_REG);
      bubble_tick();
      issue(plut_pkg::KIND_REG,   NO_REG, NO_REG,  NO_REG);
   endtask

   // Load-use stalls on either source, and the cases that must not stall.
   task automatic test_load_use_hazard();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      // use on source a; the store behind it gets refused and re-offered
      issue(plut_pkg::KIND_LOAD,  6'd5,   6'd1,    NO_REG);
      issue(plut_pkg::KIND_REG,   6'd6,   6'd5,    6'd2);
      issue(plut_pkg::KIND_STORE, NO_REG, 6'd3,    6'd5);
      // store data on source b
      issue(plut_pkg::KIND_LOAD,  6'd7,   6'd5,    NO_REG);
      issue(plut_pkg::KIND_STORE, NO_REG, 6'd2,    6'd7);
      // load without destination: no register to match
      issue(plut_pkg::KIND_LOAD,  NO_REG, 6'd0,    NO_REG);
      issue(plut_pkg::KIND_REG,   6'd1,   NO_REG,  NO_REG);
      // negative number other than -1 is no register either
      issue(plut_pkg::KIND_LOAD,  NEG_REG, 6'd0,   NO_REG);
      issue(plut_pkg::KIND_IMM,   6'd2,   NEG_REG, NEG_REG);
      // one tick apart the result forwards, no stall
      issue(plut_pkg::KIND_LOAD,  6'd10,  6'd0,    NO_REG);
      bubble_tick();
      issue(plut_pkg::KIND_REG,   6'd3,   6'd10,   6'd10);
      // load feeding a load feeding a use
      issue(plut_pkg::KIND_LOAD,  6'd11,  6'd0,    NO_REG);
      issue(plut_pkg::KIND_LOAD,  6'd12,  6'd11,   NO_REG);
      issue(plut_pkg::KIND_REG,   6'd13,  6'd12,   6'd12);
      issue(plut_pkg::KIND_REG,   6'd14,  6'd13,   6'd12);
   endtask

   function automatic logic [5:0] pick_reg();
      case ($urandom_range(0, 9))
         0:       return NO_REG;
         1:       return 6'($urandom);
         default: return 6'($urandom_range(0, 3));
      endcase
   endfunction

   // Random stream: mostly well-formed instructions over a few registers so
   // that stalls come often, plus no-offer ticks and raw noise offers that
   // are not re-offered when refused.
   task automatic test_random_stream();
      int          start;
      int          n;
      int          p;
      logic [1:0]  kind;
      logic [5:0]  d;
      logic [5:0]  a;
      logic [5:0]  b;
      logic [31:0] r;
      logic        taken;
      start = ticks_sent;
      n     = 0;
      while (ticks_sent - start < RANDOM_TICKS) begin
         // switch idling per segment, leaving some segments fully busy
         if (n % 40 == 0) begin
            req_idle_on = ($urandom_range(0, 2) != 0);
            rsp_idle_on = ($urandom_range(0, 2) != 0);
         end
         if (n == 200) wait_drain();
         p = $urandom_range(0, 99);
         if (p < 10) begin
            bubble_tick();
         end else if (p < 15) begin
            r = $urandom;
            send_tick(1'b1, r[19:0], taken);
         end else begin
            p = $urandom_range(0, 99);
            kind = (p < 35) ? plut_pkg::KIND_LOAD : (p < 55) ? plut_pkg::KIND_REG :
                   (p < 75) ? plut_pkg::KIND_IMM : plut_pkg::KIND_STORE;
            d = pick_reg();
            a = pick_reg();
            b = pick_reg();
            if (kind == plut_pkg::KIND_STORE) d = NO_REG;
            if (kind == plut_pkg::KIND_IMM || kind == plut_pkg::KIND_LOAD) b = NO_REG;
            issue(kind, d, a, b);
         end
         n++;
      end
   endtask

   // Receiver: ready in random runs, dropped for random gaps while idling
   // is on. No two changes fall on the same clock edge.
   always begin
      @(posedge clock);
      rsp_ready <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clock);
      if (rsp_idle_on) begin
         @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (idle_len() - 1) @(posedge clock);
      end
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each response transfer with the oldest owed one.
   always @(posedge clock) begin
      plut_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with none expected");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("fetch_taken",     want.fetch_taken,     rsp_fetch_taken);
            check_field("retire_valid",    want.retire_valid,    rsp_retire_valid);
            check_field("retire_seq",      want.retire_seq,      rsp_retire_seq);
            check_field("fetch_cycle",     want.fetch_cycle,     rsp_fetch_cycle);
            check_field("decode_cycle",    want.decode_cycle,    rsp_decode_cycle);
            check_field("execute_cycle",   want.execute_cycle,   rsp_execute_cycle);
            check_field("memory_cycle",    want.memory_cycle,    rsp_memory_cycle);
            check_field("writeback_cycle", want.writeback_cycle, rsp_writeback_cycle);
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("** pipeline_load_use_timing_model: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      // hold reset, then release it on an edge
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      wait_drain();
      test_load_use_hazard();
      wait_drain();
      test_random_stream();
      wait_drain();
      // allow a stray late response to show up
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** pipeline_load_use_timing_model: PASSED **");
      end else begin
         $display("** pipeline_load_use_timing_model: FAILED **");
      end
      $finish;
   end

endmodule
